// ===== rtl/core/bia_pkg.sv =====
// Shared types and constants for the bitmap identifier allocator.
// Used by every module under rtl/core; it depends on nothing else.
package bia_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int CAP_RESET = 1024;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t FULL_WORD = 32'hFFFF_FFFF;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_FULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  // Control from the sequencer to the word summary
  typedef struct packed {
    logic clear;   // forget every full mark
    logic update;  // rewrite the mark of one word
    logic full;    // new mark for that word
  } sum_ctrl_t;

  // Position of the lowest clear bit of a word (zero if there is none)
  function automatic logic [BIT_W-1:0] lowest_zero(input word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        pos = BIT_W'(b);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/bitmap_id_allocator_core.sv =====
// Bitmap identifier allocator: lowest-free-first allocation and release of
// identifiers below a configured capacity. Uses bia_pkg, bia_word_mem and
// bia_summary.
//
// Channels: requests enter on in_* (valid/stall), one result per request
// leaves on out_* (valid/stall). An allocate (opcode 0) returns the lowest
// free identifier or "pool full"; a release (opcode 1) frees in_release_id
// or reports it ignored. Every result carries the used count after it.
// cfg_* writes the pool capacity (rounded up to a multiple of 32, capped at
// MAX_IDS) and restarts the pool empty.
// Timing: a request is taken in S_IDLE; the word is read from the bitmap
// memory at that edge, then modified and written back once the result
// register is free, at the same edge that loads the result register. No new
// request is taken until that result has been registered; the
// read-modify-write of the bitmap word sets that.
// Reset and every capacity write start a clearing pass that zeroes all
// MAX_IDS/32 bitmap words (32 with the default) while in_stall is high.
// A stalled result holds in its register; the next request is still taken
// and waits in the write-back cycle until the result register frees up.
module bitmap_id_allocator_core import bia_pkg::*; #(
  parameter int MAX_IDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_pool_capacity,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [10:0] in_release_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [9:0]  out_granted_id,
  output logic [10:0] out_used_count
);

  localparam int N_WORDS    = MAX_IDS / WORD_BITS;
  localparam int WA_W       = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
  localparam int CW_W       = $clog2(N_WORDS + 1);
  localparam int CNT_W      = $clog2(MAX_IDS + 1);
  localparam int RST_WORDS  = (CAP_RESET / WORD_BITS > N_WORDS) ?
                              N_WORDS : CAP_RESET / WORD_BITS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD
  } state_t;

  state_t            state_r, state_nxt;
  logic [WA_W-1:0]   sweep_r, sweep_nxt;
  logic [CW_W-1:0]   cap_words_r, cap_words_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              op_r, op_nxt;
  logic              hit_r, hit_nxt;
  logic [WA_W-1:0]   word_r, word_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [9:0]        gid_r, gid_nxt;
  logic [10:0]       used_r, used_nxt;

  logic              accept;
  logic              cfg_wr;
  logic              commit;
  logic              out_free;
  logic [11:0]       cap_sum;
  logic [6:0]        cap_words_raw;
  logic [5:0]        rid_word_full;
  logic [WA_W-1:0]   rid_word;
  logic              rid_in_range;
  logic              free_found;
  logic [WA_W-1:0]   free_word;
  logic              rd_en;
  logic [WA_W-1:0]   rd_addr;
  word_t             rd_data;
  logic              wr_en;
  logic [WA_W-1:0]   wr_addr;
  word_t             wr_data;
  logic [BIT_W-1:0]  zero_pos;
  logic              rel_bit_set;
  logic              do_write;
  word_t             new_word;
  logic [WA_W+BIT_W-1:0] grant_id;
  sum_ctrl_t         sum_ctrl;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == S_MOD) && out_free;

  // Capacity in words: round up, then cap at the store size
  assign cap_sum       = 12'(cfg_pool_capacity) + 12'd31;
  assign cap_words_raw = cap_sum[11:5];
  assign cap_words_nxt = (32'(cap_words_raw) > 32'(N_WORDS)) ?
                         CW_W'(N_WORDS) : CW_W'(cap_words_raw);

  // Decode the word of a release and check it against the capacity
  assign rid_word_full = in_release_id[10:5];
  assign rid_word      = WA_W'(rid_word_full);
  assign rid_in_range  = 32'(rid_word_full) < 32'(cap_words_r);

  // Read the target word at the accept edge
  assign rd_en   = accept;
  assign rd_addr = (in_opcode == OP_ALLOC) ? free_word : rid_word;

  // Modify the word that came back
  assign zero_pos    = lowest_zero(rd_data);
  assign rel_bit_set = rd_data[bit_r];
  assign grant_id    = {word_r, zero_pos};

  always_comb begin
    new_word = rd_data;
    do_write = 1'b0;
    if (op_r == OP_ALLOC) begin
      new_word = rd_data | (word_t'(1) << zero_pos);
      do_write = hit_r;
    end else begin
      new_word = rd_data & ~(word_t'(1) << bit_r);
      do_write = hit_r && rel_bit_set;
    end
  end

  // Write back on commit, or zero words during the clearing pass
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = word_r;
    wr_data = new_word;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = '0;
    end else if (commit) begin
      wr_en = do_write;
    end
  end

  assign sum_ctrl.clear  = cfg_wr;
  assign sum_ctrl.update = commit && do_write;
  assign sum_ctrl.full   = (new_word == FULL_WORD);

  // Sequencer next state and result
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    hit_nxt       = hit_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    status_nxt    = status_r;
    gid_nxt       = gid_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_CLEAR: begin
        sweep_nxt = sweep_r + WA_W'(1);
        if (sweep_r == WA_W'(N_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_opcode;
          hit_nxt   = (in_opcode == OP_ALLOC) ? free_found : rid_in_range;
          word_nxt  = rd_addr;
          bit_nxt   = in_release_id[BIT_W-1:0];
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (commit) begin
          gid_nxt = '0;
          if (op_r == OP_ALLOC) begin
            if (hit_r) begin
              status_nxt = ST_GRANTED;
              gid_nxt    = 10'(grant_id);
              count_nxt  = count_r + CNT_W'(1);
            end else begin
              status_nxt = ST_FULL;
            end
          end else begin
            if (do_write) begin
              status_nxt = ST_RELEASED;
              if (count_r != '0) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end else begin
              status_nxt = ST_IGNORED;
            end
          end
          used_nxt      = 11'(count_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    // A capacity write sets the pool up afresh
    if (cfg_wr) begin
      state_nxt = S_CLEAR;
      sweep_nxt = '0;
      count_nxt = '0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      cap_words_r <= CW_W'(RST_WORDS);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        cap_words_r <= cap_words_nxt;
      end
    end
    op_r     <= op_nxt;
    hit_r    <= hit_nxt;
    word_r   <= word_nxt;
    bit_r    <= bit_nxt;
    status_r <= status_nxt;
    gid_r    <= gid_nxt;
    used_r   <= used_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_granted_id = gid_r;
  assign out_used_count = used_r;

  bia_word_mem #(
    .N_WORDS(N_WORDS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bia_summary #(
    .N_WORDS(N_WORDS)
  ) u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (sum_ctrl),
    .upd_word   (word_r),
    .cap_words  (cap_words_r),
    .free_found (free_found),
    .free_word  (free_word)
  );

endmodule

// ===== rtl/core/bia_word_mem.sv =====
// Bitmap store: one word per 32 identifiers, one write and one read port.
// Read data is registered. Uses bia_pkg.
module bia_word_mem import bia_pkg::*; #(
  parameter int N_WORDS = 32,
  localparam int WA_W = (N_WORDS > 1) ? $clog2(N_WORDS) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [WA_W-1:0] wr_addr,
  input  word_t           wr_data,
  input  logic            rd_en,
  input  logic [WA_W-1:0] rd_addr,
  output word_t           rd_data
);

  word_t mem [N_WORDS];
  word_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bia_summary.sv =====
// Word summary: one full mark per bitmap word, and the search for the
// lowest word below the capacity that still has a free bit. Uses bia_pkg.
module bia_summary import bia_pkg::*; #(
  parameter int N_WORDS = 32,
  localparam int WA_W = (N_WORDS > 1) ? $clog2(N_WORDS) : 1,
  localparam int CW_W = $clog2(N_WORDS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sum_ctrl_t       ctrl,
  input  logic [WA_W-1:0] upd_word,
  input  logic [CW_W-1:0] cap_words,
  output logic            free_found,
  output logic [WA_W-1:0] free_word
);

  logic [N_WORDS-1:0] full_r;

  // Hold the full marks; clear them at reset and on a pool setup
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      full_r <= '0;
    end else if (ctrl.update) begin
      full_r[upd_word] <= ctrl.full;
    end
  end

  // Find the lowest usable word that is not full
  always_comb begin
    free_found = 1'b0;
    free_word  = '0;
    for (int w = N_WORDS - 1; w >= 0; w--) begin
      if (!full_r[w] && (CW_W'(w) < cap_words)) begin
        free_found = 1'b1;
        free_word  = WA_W'(w);
      end
    end
  end

endmodule

// ===== rtl/core/bia_checker.sv =====
// Port-level checks for the bitmap identifier allocator, bound to the top.
// Uses bia_pkg for the status codes.
module bia_checker import bia_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [9:0]  out_granted_id,
  input logic [10:0] out_used_count
);

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_granted_id) && $stable(out_used_count))
    else $error("stalled result changed");

  // One request at a time: a taken request blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only a grant carries an identifier
  a_gid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_GRANTED) |-> out_granted_id == '0)
    else $error("identifier on a result that is not a grant");

endmodule

bind bitmap_id_allocator_core bia_checker u_bia_checker (.*);
